### rtl/core/vcho_pkg.sv
`default_nettype none
package vcho_pkg;

    localparam int SLOTS_DEF      = 64;
    localparam int MAX_CHUNKS_DEF = 44;
    localparam int CHUNK_BITS_DEF = 4;

    localparam int CELL_W      = 25;
    localparam int AXIS_W      = 21;
    localparam int KEY_W       = 3 * AXIS_W;
    localparam int HASH_W      = 32;
    localparam int FMIX_SHIFT  = 33;
    localparam int OCC_WORD_W  = 64;
    localparam int OCC_BIT_W   = 6;
    localparam int CELLS_W     = 18;
    localparam int CHUNKS_W    = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [AXIS_W-1:0] KEY_OFFSET = AXIS_W'(1 << 20);
    localparam logic [63:0]       FMIX_C1    = 64'hff51afd7ed558ccd;
    localparam logic [63:0]       FMIX_C2    = 64'hc4ceb9fe1a85ec53;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_MOD,
        F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_CMP,
        B_OREAD,
        B_OCHK,
        B_OUT
    } t_bstate;

endpackage
`default_nettype wire

### rtl/core/vcho_front.sv
`default_nettype none
module vcho_front #(
    parameter int SLOTS      = vcho_pkg::SLOTS_DEF,
    parameter int CHUNK_BITS = vcho_pkg::CHUNK_BITS_DEF,
    parameter int JOB_W      = 1 + vcho_pkg::KEY_W + 3 * CHUNK_BITS + $clog2(SLOTS)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_hold,
    input  wire logic                          i_op,
    input  wire logic [vcho_pkg::CELL_W-1:0]   i_cell_x,
    input  wire logic [vcho_pkg::CELL_W-1:0]   i_cell_y,
    input  wire logic [vcho_pkg::CELL_W-1:0]   i_cell_z,
    output logic                               o_push,
    input  wire logic                          i_full,
    output logic [JOB_W-1:0]                   o_job
);

    localparam int SW   = $clog2(SLOTS);
    localparam int LW   = 3 * CHUNK_BITS;
    localparam int KW   = vcho_pkg::KEY_W;
    localparam bit POW2 = ((1 << SW) == SLOTS);
    localparam logic [63:0] RECIP    = ((64'd1 << (32 + SW)) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
    localparam logic [31:0] RECIP_LO = RECIP[31:0];

    vcho_pkg::t_fstate r_state, n_state;

    logic              r_op;
    logic [KW-1:0]     r_key;
    logic [LW-1:0]     r_local;
    logic [63:0]       r_k, n_k;
    logic [63:0]       r_acc, n_acc;
    logic [1:0]        r_step;
    logic              r_round;
    logic [SW-1:0]     r_home, n_home;

    logic [vcho_pkg::AXIS_W-1:0] ax, ay, az;
    logic [KW-1:0]     key;
    logic [63:0]       cst, prod;
    logic [31:0]       ma, mb;
    logic [63:0]       mix;
    logic [32:0]       qsum;
    logic              accept;

    assign ax = vcho_pkg::AXIS_W'($signed(i_cell_x) >>> CHUNK_BITS) + vcho_pkg::KEY_OFFSET;
    assign ay = vcho_pkg::AXIS_W'($signed(i_cell_y) >>> CHUNK_BITS) + vcho_pkg::KEY_OFFSET;
    assign az = vcho_pkg::AXIS_W'($signed(i_cell_z) >>> CHUNK_BITS) + vcho_pkg::KEY_OFFSET;
    assign key = {ax, ay, az};

    assign o_ready = (r_state == vcho_pkg::F_IDLE) && !i_hold;
    assign accept  = i_valid && o_ready;
    assign o_push  = (r_state == vcho_pkg::F_PUSH) && !i_full;
    assign o_job   = {r_op, r_key, r_local, r_home};

    assign cst  = r_round ? vcho_pkg::FMIX_C2 : vcho_pkg::FMIX_C1;
    assign ma   = (r_state == vcho_pkg::F_MOD) ?
                  ((r_step == 2'd2) ? r_acc[31:0] : r_k[31:0]) :
                  ((r_step == 2'd1) ? r_k[63:32] : r_k[31:0]);
    assign mb   = (r_state == vcho_pkg::F_MOD) ?
                  ((r_step == 2'd2) ? 32'(SLOTS) : RECIP_LO) :
                  ((r_step == 2'd2) ? cst[63:32] : cst[31:0]);
    assign prod = ma * mb;
    assign mix  = r_acc ^ (r_acc >> vcho_pkg::FMIX_SHIFT);
    assign qsum = {1'b0, r_k[31:0]} + {1'b0, r_acc[63:32]};

    always_comb begin
        n_state = r_state;
        case (r_state)
            vcho_pkg::F_IDLE: begin
                if (accept) n_state = vcho_pkg::F_MUL;
            end
            vcho_pkg::F_MUL: begin
                if (r_step == 2'd3 && r_round) n_state = POW2 ? vcho_pkg::F_PUSH : vcho_pkg::F_MOD;
            end
            vcho_pkg::F_MOD: begin
                if (r_step == 2'd3) n_state = vcho_pkg::F_PUSH;
            end
            vcho_pkg::F_PUSH: begin
                if (!i_full) n_state = vcho_pkg::F_IDLE;
            end
            default: n_state = vcho_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        n_k    = r_k;
        n_acc  = r_acc;
        n_home = r_home;
        case (r_state)
            vcho_pkg::F_IDLE: begin
                n_k   = {1'b0, key} ^ ({1'b0, key} >> vcho_pkg::FMIX_SHIFT);
            end
            vcho_pkg::F_MUL: begin
                case (r_step)
                    2'd0: n_acc = prod;
                    2'd1, 2'd2: n_acc = {r_acc[63:32] + prod[31:0], r_acc[31:0]};
                    default: begin
                        n_k = r_round ? {mix[31:0], 32'd0} | {32'd0, mix[31:0]} : mix;
                        if (r_round) n_k = {32'd0, mix[31:0]};
                        n_home = SW'(mix[SW-1:0]);
                    end
                endcase
            end
            vcho_pkg::F_MOD: begin
                case (r_step)
                    2'd0, 2'd2: n_acc = prod;
                    2'd1: n_acc = 64'(qsum >> SW);
                    default: n_home = SW'(r_k[31:0] - r_acc[31:0]);
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vcho_pkg::F_IDLE;
            r_step  <= '0;
            r_round <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == vcho_pkg::F_IDLE) begin
                r_step  <= '0;
                r_round <= 1'b0;
            end else if (r_state == vcho_pkg::F_MUL) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) r_round <= 1'b1;
            end else if (r_state == vcho_pkg::F_MOD) begin
                r_step <= r_step + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_op;
            r_key   <= key;
            r_local <= {i_cell_x[CHUNK_BITS-1:0], i_cell_y[CHUNK_BITS-1:0],
                        i_cell_z[CHUNK_BITS-1:0]};
        end
        r_k    <= n_k;
        r_acc  <= n_acc;
        r_home <= n_home;
    end

endmodule
`default_nettype wire

### rtl/core/vcho_queue.sv
`default_nettype none
module vcho_queue #(
    parameter int DW    = 8,
    parameter int DEPTH = vcho_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [DW-1:0] i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output logic [DW-1:0]      o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DW-1:0]  r_mem [0:DEPTH-1];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
            if (i_push && !i_pop) r_cnt <= r_cnt + (AW+1)'(1);
            else if (!i_push && i_pop) r_cnt <= r_cnt - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule
`default_nettype wire

### rtl/core/vcho_back.sv
`default_nettype none
module vcho_back #(
    parameter int SLOTS      = vcho_pkg::SLOTS_DEF,
    parameter int MAX_CHUNKS = vcho_pkg::MAX_CHUNKS_DEF,
    parameter int CHUNK_BITS = vcho_pkg::CHUNK_BITS_DEF,
    parameter int JOB_W      = 1 + vcho_pkg::KEY_W + 3 * CHUNK_BITS + $clog2(SLOTS)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    output logic                  o_clearing,
    input  wire logic             i_job_valid,
    input  wire logic [JOB_W-1:0] i_job,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [31:0]           o_data
);

    localparam int SW    = $clog2(SLOTS);
    localparam int LW    = 3 * CHUNK_BITS;
    localparam int KW    = vcho_pkg::KEY_W;
    localparam int CW    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS + 1) : 1;
    localparam int WORDS = MAX_CHUNKS << (LW - vcho_pkg::OCC_BIT_W);
    localparam int OAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int OW    = vcho_pkg::OCC_WORD_W;

    vcho_pkg::t_bstate r_state, n_state;

    logic [KW-1:0]  r_slot_key   [0:SLOTS-1];
    logic [CW-1:0]  r_slot_chunk [0:SLOTS-1];
    logic [SLOTS-1:0] r_valid;
    logic [OW-1:0]  r_occ [0:WORDS-1];

    logic           r_op;
    logic [KW-1:0]  r_key;
    logic [LW-1:0]  r_local;
    logic [SW-1:0]  r_pos;
    logic [SW-1:0]  r_cnt;
    logic [CW-1:0]  r_chunk;
    logic           r_was, r_added, r_status;
    logic [CW-1:0]  r_used;
    logic [vcho_pkg::CELLS_W-1:0] r_cells;
    logic [OAW-1:0] r_clr;
    logic [KW-1:0]  r_sk_q;
    logic [CW-1:0]  r_sc_q;
    logic           r_sv_q;
    logic [OW-1:0]  r_occ_q;
    logic           r_ov;
    logic [31:0]    r_odata;

    logic           pop, out_load, alloc, set_bit, occ_we;
    logic [OAW-1:0] occ_addr, occ_waddr;
    logic [OW-1:0]  occ_wdata, bit_mask;
    logic [OAW-1:0] new_addr;
    logic [CW+LW-1:0] cat_f, cat_n;
    logic           is_query, at_end;

    assign is_query = (r_op == vcho_pkg::OP_QUERY);
    assign at_end   = (r_cnt == SW'(SLOTS - 1));
    assign cat_f    = {r_chunk, r_local};
    assign cat_n    = {r_used, r_local};
    assign occ_addr = OAW'(cat_f >> vcho_pkg::OCC_BIT_W);
    assign new_addr = OAW'(cat_n >> vcho_pkg::OCC_BIT_W);
    assign bit_mask = OW'(1) << r_local[vcho_pkg::OCC_BIT_W-1:0];

    assign o_clearing = (r_state == vcho_pkg::B_CLEAR);
    assign pop        = (r_state == vcho_pkg::B_IDLE) && i_job_valid;
    assign o_pop      = pop;
    assign out_load   = (r_state == vcho_pkg::B_OUT) && (!r_ov || i_ready);
    assign alloc      = (r_state == vcho_pkg::B_CMP) && !r_sv_q && !is_query &&
                        (r_used < CW'(MAX_CHUNKS));
    assign set_bit    = (r_state == vcho_pkg::B_OCHK) && !is_query &&
                        !r_occ_q[r_local[vcho_pkg::OCC_BIT_W-1:0]];
    assign o_valid    = r_ov;
    assign o_data     = r_odata;

    always_comb begin
        n_state = r_state;
        case (r_state)
            vcho_pkg::B_CLEAR: begin
                if (r_clr == OAW'(WORDS - 1)) n_state = vcho_pkg::B_IDLE;
            end
            vcho_pkg::B_IDLE: begin
                if (i_job_valid) n_state = vcho_pkg::B_READ;
            end
            vcho_pkg::B_READ: n_state = vcho_pkg::B_CMP;
            vcho_pkg::B_CMP: begin
                if (!r_sv_q) n_state = vcho_pkg::B_OUT;
                else if (r_sk_q == r_key) n_state = vcho_pkg::B_OREAD;
                else if (at_end) n_state = vcho_pkg::B_OUT;
                else n_state = vcho_pkg::B_READ;
            end
            vcho_pkg::B_OREAD: n_state = vcho_pkg::B_OCHK;
            vcho_pkg::B_OCHK:  n_state = vcho_pkg::B_OUT;
            vcho_pkg::B_OUT: begin
                if (!r_ov || i_ready) n_state = vcho_pkg::B_IDLE;
            end
            default: n_state = vcho_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        occ_we    = 1'b0;
        occ_waddr = r_clr;
        occ_wdata = '0;
        case (r_state)
            vcho_pkg::B_CLEAR: occ_we = 1'b1;
            vcho_pkg::B_CMP: begin
                occ_we    = alloc;
                occ_waddr = new_addr;
                occ_wdata = bit_mask;
            end
            vcho_pkg::B_OCHK: begin
                occ_we    = set_bit;
                occ_waddr = occ_addr;
                occ_wdata = r_occ_q | bit_mask;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (occ_we) r_occ[occ_waddr] <= occ_wdata;
        r_occ_q <= r_occ[occ_addr];
    end

    always_ff @(posedge i_clk) begin
        if (alloc) begin
            r_slot_key[r_pos]   <= r_key;
            r_slot_chunk[r_pos] <= r_used;
        end
        r_sk_q <= r_slot_key[r_pos];
        r_sc_q <= r_slot_chunk[r_pos];
        r_sv_q <= r_valid[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vcho_pkg::B_CLEAR;
            r_clr   <= '0;
            r_valid <= '0;
            r_used  <= '0;
            r_cells <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == vcho_pkg::B_CLEAR) r_clr <= r_clr + OAW'(1);
            if (alloc) begin
                r_valid[r_pos] <= 1'b1;
                r_used         <= r_used + CW'(1);
            end
            if (alloc || set_bit) r_cells <= r_cells + vcho_pkg::CELLS_W'(1);
            if (out_load) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            vcho_pkg::B_IDLE: begin
                if (pop) begin
                    {r_op, r_key, r_local, r_pos} <= i_job;
                end
                r_cnt    <= '0;
                r_was    <= 1'b0;
                r_added  <= 1'b0;
                r_status <= 1'b0;
            end
            vcho_pkg::B_CMP: begin
                if (!r_sv_q) begin
                    r_added  <= alloc;
                    r_status <= !is_query && !alloc;
                end else if (r_sk_q == r_key) begin
                    r_chunk <= r_sc_q;
                end else if (at_end) begin
                    r_status <= !is_query;
                end else begin
                    r_pos <= (r_pos == SW'(SLOTS - 1)) ? '0 : r_pos + SW'(1);
                    r_cnt <= r_cnt + SW'(1);
                end
            end
            vcho_pkg::B_OCHK: begin
                r_was   <= r_occ_q[r_local[vcho_pkg::OCC_BIT_W-1:0]];
                r_added <= set_bit;
            end
            default: ;
        endcase
        if (out_load) begin
            r_odata <= {5'd0, vcho_pkg::CHUNKS_W'(r_used), r_cells, r_status, r_added, r_was};
        end
    end

endmodule
`default_nettype wire

### rtl/core/voxel_chunk_hash_occupancy_map_unit.sv
`default_nettype none
// Sparse voxel occupancy set kept as cubic chunks in an open-addressed hash
// table. Each input transfer inserts a cell (tuser 0) or asks whether it is
// solid (tuser 1) and yields one result transfer. After reset the block
// clears all MAX_CHUNKS * 2^(3*CHUNK_BITS-6) words of its occupancy memory
// (2816 by default) and takes no transfer meanwhile. The front hashes a key
// with one 32x32 multiplier, plus a reciprocal remainder when SLOTS is not
// a power of two, and takes a new item only once it has pushed the job of
// the last one. The back handles one job at a time: it takes the job, reads
// and compares a slot per probe, reads and updates the cell word of an
// existing chunk, then loads the result. A two-entry queue couples the two.
module voxel_chunk_hash_occupancy_map_unit #(
    parameter int SLOTS      = vcho_pkg::SLOTS_DEF,
    parameter int MAX_CHUNKS = vcho_pkg::MAX_CHUNKS_DEF,
    parameter int CHUNK_BITS = vcho_pkg::CHUNK_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [79:0] i_s_tdata,  // cell_x[24:0], cell_y[49:25], cell_z[74:50]
    input  wire logic        i_s_tuser,  // op
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata   // was_solid, added, status, cell_total[20:3],
                                         // chunk_total[26:21]
);

    localparam int JOB_W = 1 + vcho_pkg::KEY_W + 3 * CHUNK_BITS + $clog2(SLOTS);

    logic             clearing;
    logic             push, full, q_valid, pop;
    logic [JOB_W-1:0] job_in, job_out;

    vcho_front #(
        .SLOTS      (SLOTS),
        .CHUNK_BITS (CHUNK_BITS),
        .JOB_W      (JOB_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_hold   (clearing),
        .i_op     (i_s_tuser),
        .i_cell_x (i_s_tdata[24:0]),
        .i_cell_y (i_s_tdata[49:25]),
        .i_cell_z (i_s_tdata[74:50]),
        .o_push   (push),
        .i_full   (full),
        .o_job    (job_in)
    );

    vcho_queue #(
        .DW    (JOB_W),
        .DEPTH (vcho_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (job_out)
    );

    vcho_back #(
        .SLOTS      (SLOTS),
        .MAX_CHUNKS (MAX_CHUNKS),
        .CHUNK_BITS (CHUNK_BITS),
        .JOB_W      (JOB_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_clearing  (clearing),
        .i_job_valid (q_valid),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_data      (o_m_tdata)
    );

endmodule
`default_nettype wire
